[hw/rtl/vks_pkg.sv]
// ----------------------------------------------------------------------------
// vks_pkg
// Shared sizes, status codes and store request type for the visited key set.
// ----------------------------------------------------------------------------
package vks_pkg;

	localparam int KEY_BITS      = 64;
	localparam int STORE_ENTRIES = 1024;
	localparam int TAIL_LIMIT    = 32;

	localparam int IDX_W = $clog2(STORE_ENTRIES);
	localparam int CNT_W = $clog2(STORE_ENTRIES + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// result codes
	localparam logic [1:0] STATUS_NEW  = 2'd0;
	localparam logic [1:0] STATUS_SEEN = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// one access to the key store per cycle
	typedef struct packed {
		logic we;
		idx_t addr;
		key_t wdata;
	} store_req_t;

endpackage

[hw/rtl/vks_store.sv]
// ----------------------------------------------------------------------------
// vks_store
// Single-port key store, synchronous write, registered read data.
// ----------------------------------------------------------------------------
module vks_store
	import vks_pkg::*;
(
	input  logic       clk,
	input  store_req_t req,
	output key_t       rdata
);

	key_t mem [STORE_ENTRIES];

	// one read or one write per cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else begin
			rdata <= mem[req.addr];
		end
	end

endmodule

[hw/rtl/visited_key_set.sv]
// ----------------------------------------------------------------------------
// visited_key_set
// Seen-set engine: binary search over a sorted region, scan of an unsorted
// tail, append of new keys and insertion-sort merge of a full tail.
// ----------------------------------------------------------------------------
// One key is handled at a time over a single-port store with registered
// read data. A lookup runs binary-search probes over the sorted region,
// scans the tail entry by entry, appends a key found in neither and hands
// off the result; an exhausted block answers full without searching. When
// a key fills the tail, its result is delivered first and then the tail is
// merged: each tail entry is read, larger entries before it are shifted up
// one slot and it is written into the gap. If too little room is left, the
// key is answered full and the block becomes exhausted instead. No key is
// accepted during the merge. The result sits in an output register, so the
// next key may be taken while it waits; a result that is ready while the
// previous one still waits holds the block until it drains.
// ----------------------------------------------------------------------------
module visited_key_set
	import vks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status
);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_BS_RD  = 12'b000000000010,
		ST_BS_CMP = 12'b000000000100,
		ST_TL_RD  = 12'b000000001000,
		ST_TL_CMP = 12'b000000010000,
		ST_APPEND = 12'b000000100000,
		ST_RES    = 12'b000001000000,
		ST_M_RDI  = 12'b000010000000,
		ST_M_LDV  = 12'b000100000000,
		ST_M_RDJ  = 12'b001000000000,
		ST_M_CMP  = 12'b010000000000,
		ST_M_WR   = 12'b100000000000
	} state_t;

	state_t     state_q;
	key_t       key_q;
	key_t       v_q;
	cnt_t       sorted_q, tail_q, free_q;
	cnt_t       lo_q, hi_q, mid_q, i_q, j_q, end_q;
	logic       exhausted_q;
	logic       merge_q;
	logic [1:0] res_q;
	logic       out_valid_q;
	logic [1:0] status_q;

	store_req_t req;
	key_t       rdata;

	cnt_t mid;
	cnt_t slot;
	cnt_t tail_nxt;
	cnt_t free_nxt;
	cnt_t tl_addr;
	cnt_t jm1;

	vks_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign slot     = sorted_q + tail_q;
	assign tail_nxt = tail_q + cnt_t'(1);
	assign free_nxt = (free_q >= tail_nxt) ? free_q - tail_nxt : '0;
	assign tl_addr  = sorted_q + i_q;
	assign jm1      = j_q - cnt_t'(1);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;

	// store access for the current step
	always_comb begin
		req = '{we: 1'b0, addr: '0, wdata: v_q};
		unique case (state_q)
			ST_BS_RD:  req.addr = mid[IDX_W-1:0];
			ST_TL_RD:  req.addr = tl_addr[IDX_W-1:0];
			ST_APPEND: begin
				req.we    = (int'(slot) < STORE_ENTRIES);
				req.addr  = slot[IDX_W-1:0];
				req.wdata = key_q;
			end
			ST_M_RDI:  req.addr = i_q[IDX_W-1:0];
			ST_M_RDJ:  req.addr = jm1[IDX_W-1:0];
			ST_M_CMP:  begin
				req.we    = (rdata > v_q);
				req.addr  = j_q[IDX_W-1:0];
				req.wdata = rdata;
			end
			ST_M_WR:   begin
				req.we   = 1'b1;
				req.addr = j_q[IDX_W-1:0];
			end
			default:   req.addr = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sorted_q    <= '0;
			tail_q      <= '0;
			free_q      <= cnt_t'(STORE_ENTRIES);
			exhausted_q <= 1'b0;
			merge_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q   <= key[KEY_BITS-1:0];
						lo_q    <= '0;
						hi_q    <= sorted_q;
						i_q     <= '0;
						merge_q <= 1'b0;
						res_q   <= STATUS_FULL;
						state_q <= exhausted_q ? ST_RES : ST_BS_RD;
					end
				end
				ST_BS_RD: begin
					mid_q   <= mid;
					state_q <= (lo_q < hi_q) ? ST_BS_CMP : ST_TL_RD;
				end
				ST_BS_CMP: begin
					if (rdata == key_q) begin
						res_q   <= STATUS_SEEN;
						state_q <= ST_RES;
					end else begin
						if (rdata < key_q) begin
							lo_q <= mid_q + cnt_t'(1);
						end else begin
							hi_q <= mid_q;
						end
						state_q <= ST_BS_RD;
					end
				end
				ST_TL_RD: begin
					state_q <= (i_q < tail_q) ? ST_TL_CMP : ST_APPEND;
				end
				ST_TL_CMP: begin
					if (rdata == key_q) begin
						res_q   <= STATUS_SEEN;
						state_q <= ST_RES;
					end else begin
						i_q     <= i_q + cnt_t'(1);
						state_q <= ST_TL_RD;
					end
				end
				ST_APPEND: begin
					state_q <= ST_RES;
					if (int'(slot) >= STORE_ENTRIES) begin
						exhausted_q <= 1'b1;
						res_q       <= STATUS_FULL;
					end else begin
						tail_q <= tail_nxt;
						res_q  <= STATUS_NEW;
						if (int'(tail_nxt) >= TAIL_LIMIT) begin
							free_q <= free_nxt;
							if (int'(free_nxt) <= TAIL_LIMIT) begin
								exhausted_q <= 1'b1;
								res_q       <= STATUS_FULL;
							end else begin
								merge_q <= 1'b1;
								i_q     <= sorted_q;
								end_q   <= slot + cnt_t'(1);
							end
						end
					end
				end
				ST_RES: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_q;
						state_q     <= merge_q ? ST_M_RDI : ST_IDLE;
					end
				end
				ST_M_RDI: begin
					state_q <= ST_M_LDV;
				end
				ST_M_LDV: begin
					v_q     <= rdata;
					j_q     <= i_q;
					state_q <= ST_M_RDJ;
				end
				ST_M_RDJ: begin
					state_q <= (j_q == '0) ? ST_M_WR : ST_M_CMP;
				end
				ST_M_CMP: begin
					if (rdata > v_q) begin
						j_q     <= j_q - cnt_t'(1);
						state_q <= ST_M_RDJ;
					end else begin
						state_q <= ST_M_WR;
					end
				end
				ST_M_WR: begin
					i_q <= i_q + cnt_t'(1);
					if (i_q + cnt_t'(1) == end_q) begin
						sorted_q <= end_q;
						tail_q   <= '0;
						merge_q  <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_M_RDI;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// occupied slots never run past the store
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sorted_q) + int'(tail_q) <= STORE_ENTRIES)
		else $error("sorted region plus tail exceeds the store");

	// a waiting key never sees a full tail unless the block is exhausted
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !exhausted_q) |-> (int'(tail_q) < TAIL_LIMIT))
		else $error("tail full while idle");

	// the store is not written while idle
	a_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !req.we)
		else $error("store write while idle");

	// a key accepted while exhausted is answered as full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && exhausted_q) |=> (res_q == STATUS_FULL))
		else $error("exhausted block gave a non-full answer");

endmodule
